[design/svm_pkg.sv]
// shared types and constants of the sample voice mixer
package svm_pkg;

  localparam int SLOTS = 32;
  localparam int VOICES = 64;
  localparam int MEMORY_FRAMES = 65536;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int VOICE_W = $clog2(VOICES);
  localparam int ADDR_W = $clog2(MEMORY_FRAMES);
  localparam int GAIN_W = 17;
  localparam int ACC_W = 40;

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_DEFINE = 3'd1;
  localparam logic [2:0] CMD_GAIN = 3'd2;
  localparam logic [2:0] CMD_TRIGGER = 3'd3;
  localparam logic [2:0] CMD_TICK = 3'd4;

  typedef struct packed {
    logic [2:0] command;
    logic [4:0] slot_index;
    logic [15:0] sample_address;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic [15:0] slot_base;
    logic [15:0] slot_length;
    logic [15:0] start_frame;
    logic [15:0] end_frame;
    logic [15:0] volume;
  } request_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic clipped;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic exec;       // run a non-tick request
    logic tick_init;  // clear accumulators, set up block
    logic voice_rd;   // read voice state and sample for cur voice
    logic voice_acc;  // accumulate and update cur voice
    logic tick_done;  // finish block position, emit result
    logic [VOICE_W-1:0] voice;
  } ctrl_t;

endpackage

[design/sample_voice_mixer.sv]
// top level of the sample voice mixer
// Usage: a request is taken when start is high and busy is low. Commands
// write a stereo frame, define a slot, set a slot gain, trigger a voice or
// tick. Non-tick requests finish in the accept cycle and busy stays low.
// A tick walks all 64 voices, each a sample memory read state then a
// multiply-accumulate state, then a finishing state: busy is high for the
// whole walk, and the mixed frame appears on result with done high for one
// cycle, registered from the finishing state. No request is taken meanwhile.
// Configuration: cfg_valid/cfg_ready write block_frames; cfg_ready is high
// whenever busy is low. Reset clears all slots, voices and the block
// position and sets block_frames to 64; sample memory is not cleared.
// The receiver cannot stall: results must be taken in the done cycle.
module sample_voice_mixer import svm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  request_t request,
  output logic busy,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [8:0] cfg_data,
  output result_t result,
  output logic done
);

  ctrl_t ctrl;
  logic [8:0] block_frames;

  assign cfg_ready = !busy;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) block_frames <= 9'd64;
    else if (cfg_valid && cfg_ready) block_frames <= cfg_data;
  end

  svm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .command(request.command),
    .busy(busy), .ctrl(ctrl)
  );

  svm_datapath u_dp (
    .clk(clk), .rst(rst), .req(request), .ctrl(ctrl),
    .block_frames(block_frames), .result(result), .done(done)
  );

endmodule

[design/svm_ctrl.sv]
// controller state machine sequencing a tick over all voices
module svm_ctrl import svm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [2:0] command,
  output logic busy,
  output ctrl_t ctrl
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_ACC  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [VOICE_W-1:0] voice, voice_next;
  logic go;

  assign go = start && !busy;
  assign busy = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    voice_next = voice;
    case (state)
      S_IDLE: begin
        if (go && command == CMD_TICK) begin
          state_next = S_READ;
          voice_next = '0;
        end
      end
      S_READ: state_next = S_ACC;
      S_ACC: begin
        if (voice == VOICE_W'(VOICES - 1)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_READ;
          voice_next = voice + 1'b1;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      voice <= '0;
    end else begin
      state <= state_next;
      voice <= voice_next;
    end
  end

  // commands
  always_comb begin
    ctrl.exec = go && command != CMD_TICK;
    ctrl.tick_init = go && command == CMD_TICK;
    ctrl.voice_rd = (state == S_READ);
    ctrl.voice_acc = (state == S_ACC);
    ctrl.tick_done = (state == S_DONE);
    ctrl.voice = voice;
  end

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && voice != VOICE_W'(VOICES - 1)) |=> state == S_READ)
    else $error("walk stopped early");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> state == S_IDLE)
    else $error("done not followed by idle");
  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    ctrl.tick_init |=> (state == S_READ && voice == '0))
    else $error("tick did not start walk");
`endif

endmodule

[design/svm_datapath.sv]
// slot and voice state, sample memory and mixing accumulators
module svm_datapath import svm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  request_t req,
  input  ctrl_t ctrl,
  input  logic [8:0] block_frames,
  output result_t result,
  output logic done
);

  logic [31:0] mem [MEMORY_FRAMES];
  logic [15:0] slot_start [SLOTS];
  logic [15:0] slot_frames [SLOTS];
  logic [SLOTS-1:0] slot_loaded;
  logic [GAIN_W-1:0] slot_gain [SLOTS];
  logic [VOICES-1:0] voice_active;
  logic [VOICES-1:0] voice_fresh;
  logic [SLOT_W-1:0] voice_slot [VOICES];
  logic [15:0] voice_playhead [VOICES];
  logic [15:0] voice_end [VOICES];
  logic [GAIN_W-1:0] voice_gain [VOICES];
  logic [VOICE_W-1:0] next_voice;
  logic [7:0] block_position;
  logic [8:0] bf, remaining;
  logic signed [ACC_W-1:0] accl, accr;
  logic [31:0] word;
  logic [GAIN_W-1:0] gain_r;
  logic use_r, kill_r, chk_r;
  logic [VOICE_W-1:0] v;
  logic [VOICE_W-1:0] fetch_v;
  logic [SLOT_W-1:0] vs;
  logic [15:0] ph_r, end_r;
  logic [16:0] last;
  logic chk, kill, play;
  logic signed [33:0] prod_l, prod_r;
  logic signed [ACC_W-1:0] rl, rr;
  logic signed [ACC_W-17:0] ql, qr;
  logic [17:0] gain_x3;

  // clamp block size
  always_comb begin
    if (block_frames == 9'd0) bf = 9'd1;
    else if (block_frames > 9'd256) bf = 9'd256;
    else bf = block_frames;
    remaining = bf - {1'b0, block_position};
  end

  assign v = ctrl.voice;
  assign fetch_v = ctrl.tick_init ? '0 : v + 1'b1;
  assign last = {1'b0, ph_r} + {8'd0, remaining};
  assign chk = block_position == 8'd0 || voice_fresh[v];
  assign kill = chk && (last >= {1'b0, end_r} || last >= {1'b0, slot_frames[vs]});
  assign play = voice_active[v] && slot_loaded[vs];
  assign gain_x3 = {1'b0, req.volume, 1'b0} + {2'b0, req.volume};

  // registered read of the voice state for the next voice of the walk
  always_ff @(posedge clk) begin
    if (ctrl.tick_init || ctrl.voice_acc) begin
      vs <= voice_slot[fetch_v];
      ph_r <= voice_playhead[fetch_v];
      end_r <= voice_end[fetch_v];
      gain_r <= voice_gain[fetch_v];
    end
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (ctrl.exec && req.command == CMD_WRITE)
      mem[req.sample_address[ADDR_W-1:0]] <= {req.right_in, req.left_in};
    if (ctrl.voice_rd)
      word <= mem[ADDR_W'(slot_start[vs] + ph_r)];
  end

  // per voice decision registers
  always_ff @(posedge clk) begin
    if (ctrl.voice_rd) begin
      use_r <= play;
      kill_r <= kill;
      chk_r <= chk;
    end
  end

  // slot tables and voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_loaded <= '0;
      voice_active <= '0;
      voice_fresh <= '0;
      next_voice <= '0;
      block_position <= '0;
      for (int i = 0; i < SLOTS; i++) slot_gain[i] <= '0;
    end else begin
      if (ctrl.exec && req.command == CMD_DEFINE) begin
        slot_start[req.slot_index] <= req.slot_base;
        slot_frames[req.slot_index] <= req.slot_length;
        slot_loaded[req.slot_index] <= 1'b1;
      end
      if (ctrl.exec && req.command == CMD_GAIN)
        slot_gain[req.slot_index] <= gain_x3[17:1];
      if (ctrl.exec && req.command == CMD_TRIGGER) begin
        voice_active[next_voice] <= 1'b1;
        voice_slot[next_voice] <= req.slot_index;
        voice_playhead[next_voice] <= req.start_frame;
        voice_end[next_voice] <= req.end_frame;
        voice_gain[next_voice] <= slot_gain[req.slot_index];
        voice_fresh[next_voice] <= 1'b1;
        next_voice <= (next_voice == VOICE_W'(VOICES - 1)) ? '0 : next_voice + 1'b1;
      end
      if (ctrl.tick_init && {1'b0, block_position} >= bf) block_position <= '0;
      if (ctrl.voice_acc && use_r) begin
        if (chk_r) voice_fresh[v] <= 1'b0;
        if (kill_r) voice_active[v] <= 1'b0;
        else voice_playhead[v] <= ph_r + 16'd1;
      end
      if (ctrl.tick_done) begin
        if ({1'b0, block_position} + 9'd1 >= bf) block_position <= '0;
        else block_position <= block_position + 8'd1;
      end
    end
  end

  // multiply and accumulate
  assign prod_l = $signed(word[15:0]) * $signed({1'b0, gain_r});
  assign prod_r = $signed(word[31:16]) * $signed({1'b0, gain_r});
  always_ff @(posedge clk) begin
    if (ctrl.tick_init) begin
      accl <= '0;
      accr <= '0;
    end else if (ctrl.voice_acc && use_r && !kill_r) begin
      accl <= accl + ACC_W'(prod_l);
      accr <= accr + ACC_W'(prod_r);
    end
  end

  // round and saturate
  assign rl = (accl + ACC_W'(32768)) >>> 16;
  assign rr = (accr + ACC_W'(32768)) >>> 16;
  assign ql = rl[ACC_W-17:0];
  assign qr = rr[ACC_W-17:0];
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= ctrl.tick_done;
    if (ctrl.tick_done) begin
      result.clipped <= (ql > 32767) || (ql < -32768) || (qr > 32767) || (qr < -32768);
      result.left_out <= (ql > 32767) ? 16'sh7fff : (ql < -32768) ? 16'sh8000 : ql[15:0];
      result.right_out <= (qr > 32767) ? 16'sh7fff : (qr < -32768) ? 16'sh8000 : qr[15:0];
    end
  end

`ifndef ASSERT_OFF
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result repeated");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.tick_done |=> {1'b0, block_position} < bf)
    else $error("block position past block");
  a_kill_clears: assert property (@(posedge clk) disable iff (rst)
    (ctrl.voice_acc && use_r && kill_r) |=> !voice_active[$past(v)])
    else $error("voice not deactivated");
`endif

endmodule

[verif/tb.sv]
// testbench for the sample voice mixer: directed and random requests checked against a predictor
module tb import svm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 140;
  localparam int REQ_W = $bits(request_t);
  // written window of sample memory; slot bases and lengths stay small enough
  // that every playhead, even one carried past its check by a larger block,
  // reads inside it
  localparam int FILL_FRAMES = 768;
  localparam int BASE_SPAN = 63;
  localparam int LEN_SPAN = 448;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  request_t request = '0;
  logic busy;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [8:0] cfg_data = 9'd64;
  result_t result;
  logic done;

  sample_voice_mixer DUT (
    .clk(clk), .rst(rst), .start(start), .request(request), .busy(busy),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result(result), .done(done)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] frame_mem [MEMORY_FRAMES];
  logic [15:0] slot_base_q [SLOTS];
  logic [15:0] slot_len_q [SLOTS];
  logic slot_ready_q [SLOTS];
  logic [16:0] slot_gain_q [SLOTS];
  logic voice_on [VOICES];
  logic [4:0] voice_slot_q [VOICES];
  logic [15:0] voice_pos [VOICES];
  logic [15:0] voice_stop [VOICES];
  logic [16:0] voice_gain_q [VOICES];
  logic voice_new [VOICES];
  int unsigned voice_rr;
  int unsigned frame_in_block;
  logic [8:0] block_len;

  result_t mixed_frames [$];
  int errors = 0;
  int ticks_checked = 0;
  int requests_sent = 0;
  bit idling = 1'b1;
  int stall_count = 0;

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic [15:0] to_q15(input longint acc, inout bit clip);
    longint r;
    r = (acc + 64'sd32768) >>> 16;
    if (r > 32767) begin
      clip = 1'b1;
      return 16'h7fff;
    end
    if (r < -32768) begin
      clip = 1'b1;
      return 16'h8000;
    end
    return r[15:0];
  endfunction

  // one tick of the mix
  function automatic result_t mix_frame();
    int unsigned bf;
    int unsigned remaining;
    int unsigned last;
    longint acc_l;
    longint acc_r;
    logic [31:0] word;
    logic [4:0] s;
    bit clip;
    result_t r;
    acc_l = 0;
    acc_r = 0;
    clip = 1'b0;
    bf = block_len;
    if (bf == 0) bf = 1;
    if (bf > 256) bf = 256;
    if (frame_in_block >= bf) frame_in_block = 0;
    remaining = bf - frame_in_block;
    for (int v = 0; v < VOICES; v++) begin
      if (!voice_on[v]) continue;
      s = voice_slot_q[v];
      if (!slot_ready_q[s]) continue;
      if (frame_in_block == 0 || voice_new[v]) begin
        voice_new[v] = 1'b0;
        last = voice_pos[v] + remaining;
        if (last >= voice_stop[v] || last >= slot_len_q[s]) begin
          voice_on[v] = 1'b0;
          continue;
        end
      end
      word = frame_mem[16'(slot_base_q[s] + voice_pos[v])];
      acc_l += longint'($signed(word[15:0])) * longint'(voice_gain_q[v]);
      acc_r += longint'($signed(word[31:16])) * longint'(voice_gain_q[v]);
      voice_pos[v] = voice_pos[v] + 16'd1;
    end
    frame_in_block++;
    if (frame_in_block >= bf) frame_in_block = 0;
    r.left_out = to_q15(acc_l, clip);
    r.right_out = to_q15(acc_r, clip);
    r.clipped = clip;
    return r;
  endfunction

  // apply one accepted request to the predictor
  function automatic void apply_request(input request_t q);
    case (q.command)
      CMD_WRITE: frame_mem[q.sample_address] = {q.right_in, q.left_in};
      CMD_DEFINE: begin
        slot_base_q[q.slot_index] = q.slot_base;
        slot_len_q[q.slot_index] = q.slot_length;
        slot_ready_q[q.slot_index] = 1'b1;
      end
      CMD_GAIN: slot_gain_q[q.slot_index] = 17'((32'(q.volume) * 3) >> 1);
      CMD_TRIGGER: begin
        voice_on[voice_rr] = 1'b1;
        voice_slot_q[voice_rr] = q.slot_index;
        voice_pos[voice_rr] = q.start_frame;
        voice_stop[voice_rr] = q.end_frame;
        voice_gain_q[voice_rr] = slot_gain_q[q.slot_index];
        voice_new[voice_rr] = 1'b1;
        voice_rr = (voice_rr + 1) % VOICES;
      end
      CMD_TICK: mixed_frames.push_back(mix_frame());
      default: ;
    endcase
  endfunction

  // send one request and wait for it to be taken
  task automatic send(input request_t q);
    start <= 1'b1;
    request <= q;
    do @(posedge clk); while (busy);
    apply_request(q);
    requests_sent++;
  endtask

  task automatic pause();
    int n;
    if (idling && $urandom_range(3) == 0) begin
      n = $urandom_range(10, 1);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // write block_frames once all pending frames are out
  task automatic set_block(input logic [8:0] bf);
    start <= 1'b0;
    while (mixed_frames.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= bf;
    do @(posedge clk); while (!cfg_ready);
    block_len = bf;
    cfg_valid <= 1'b0;
  endtask

  function automatic request_t make(input logic [2:0] cmd, input logic [4:0] slot);
    request_t q;
    q = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    q.command = cmd;
    q.slot_index = slot;
    return q;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (mixed_frames.size() == 0) begin
        report("unexpected frame", result.left_out, 16'h0);
      end else begin
        result_t w;
        w = mixed_frames.pop_front();
        ticks_checked++;
        if (result.left_out !== w.left_out) report("left_out", result.left_out, w.left_out);
        if (result.right_out !== w.right_out) report("right_out", result.right_out, w.right_out);
        if (result.clipped !== w.clipped) report("clipped", 16'(result.clipped), 16'(w.clipped));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("watchdog expired with %0d frames pending", mixed_frames.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // fill the low window of sample memory that the random traffic reads from
  task automatic test_memory_fill();
    request_t q;
    for (int a = 0; a < FILL_FRAMES; a++) begin
      q = make(CMD_WRITE, 5'd0);
      q.sample_address = 16'(a);
      send(q);
    end
    start <= 1'b0;
  endtask

  // extremes, clipping, memory wrap, zero length, unknown commands
  task automatic test_directed();
    request_t q;
    set_block(9'd1);
    q = make(CMD_WRITE, 5'd0); q.sample_address = 16'd0; q.left_in = 16'sh7fff;
    q.right_in = 16'sh8000; send(q);
    q = make(CMD_WRITE, 5'd0); q.sample_address = 16'hffff; q.left_in = 16'sh8000;
    q.right_in = 16'sh7fff; send(q);
    q = make(CMD_GAIN, 5'd3); q.volume = 16'hffff; send(q);
    q = make(CMD_GAIN, 5'd31); q.volume = 16'h0; send(q);
    q = make(CMD_DEFINE, 5'd3); q.slot_base = 16'd0; q.slot_length = 16'd4; send(q);
    q = make(CMD_DEFINE, 5'd31); q.slot_base = 16'hffff; q.slot_length = 16'hffff; send(q);
    q = make(CMD_DEFINE, 5'd0); q.slot_base = 16'd100; q.slot_length = 16'd0; send(q);
    for (int i = 0; i < 4; i++) begin
      q = make(CMD_TRIGGER, 5'd3); q.start_frame = 16'd0; q.end_frame = 16'hffff; send(q);
    end
    q = make(CMD_TRIGGER, 5'd31); q.start_frame = 16'd0; q.end_frame = 16'hffff; send(q);
    q = make(CMD_TRIGGER, 5'd31); q.start_frame = 16'hffff; q.end_frame = 16'hffff; send(q);
    q = make(CMD_TRIGGER, 5'd0); q.start_frame = 16'd0; q.end_frame = 16'd50; send(q);
    q = make(CMD_TRIGGER, 5'd7); q.start_frame = 16'd0; q.end_frame = 16'd50; send(q);
    for (int c = 5; c < 8; c++) begin
      q = make(3'(c), 5'd3); send(q);
    end
    for (int i = 0; i < 6; i++) begin
      q = make(CMD_TICK, 5'd0); send(q);
    end
    // retire the wrapping voice before longer blocks start
    q = make(CMD_DEFINE, 5'd31); q.slot_base = 16'd0; q.slot_length = 16'd0; send(q);
    q = make(CMD_TICK, 5'd0); send(q);
    start <= 1'b0;
  endtask

  // mostly well-formed playback traffic with random content
  task automatic test_random(input int n);
    request_t q;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) q = make(CMD_WRITE, 5'($urandom));
      else if (pick < 16) begin
        q = make(CMD_DEFINE, 5'($urandom));
        q.slot_base = 16'($urandom_range(BASE_SPAN));
        q.slot_length = 16'($urandom_range(LEN_SPAN));
      end else if (pick < 24) q = make(CMD_GAIN, 5'($urandom));
      else if (pick < 52) begin
        q = make(CMD_TRIGGER, 5'($urandom));
        if ($urandom_range(4) != 0) begin
          q.start_frame = 16'($urandom_range(60));
          q.end_frame = q.start_frame + 16'($urandom_range(1500));
        end
      end else if (pick < 97) q = make(CMD_TICK, 5'($urandom));
      else q = make(3'($urandom_range(7, 5)), 5'($urandom));
      send(q);
      pause();
    end
    start <= 1'b0;
  endtask

  // walk block sizes including the extremes and out-of-range codes
  task automatic test_block_sizes();
    logic [8:0] sizes [6] = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd64, 9'd17};
    foreach (sizes[k]) begin
      set_block(sizes[k]);
      test_random(30);
    end
    set_block(9'($urandom_range(511)));
    test_random(30);
  endtask

  task automatic test_no_idle();
    idling = 1'b0;
    set_block(9'd32);
    test_random(50);
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      slot_base_q[s] = 0; slot_len_q[s] = 0; slot_ready_q[s] = 0; slot_gain_q[s] = 0;
    end
    for (int v = 0; v < VOICES; v++) begin
      voice_on[v] = 0; voice_slot_q[v] = 0; voice_pos[v] = 0;
      voice_stop[v] = 0; voice_gain_q[v] = 0; voice_new[v] = 0;
    end
    voice_rr = 0;
    frame_in_block = 0;
    block_len = 9'd64;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_memory_fill();
    test_directed();
    test_block_sizes();
    test_no_idle();
    while (mixed_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d mixed frames checked over eight block sizes",
             requests_sent, ticks_checked);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
